@@ rtl/ts2u_pkg.sv @@
// Package: shared types, constants and code page 437 glyph tables.
`timescale 1ns / 1ps
package ts2u_pkg;

  localparam int CharW   = 8;
  localparam int BudgetW = 24;
  localparam int RunW    = 8;
  localparam int LenW    = 2;

  localparam logic [CharW-1:0]   DEFAULT_ROW_WIDTH   = 8'd80;
  localparam logic [BudgetW-1:0] DEFAULT_BYTE_BUDGET = 24'hFFFFFF;
  localparam logic [CharW-1:0]   CHAR_NUL            = 8'h00;
  localparam logic [CharW-1:0]   CHAR_SPACE          = 8'h20;
  localparam logic [CharW-1:0]   CHAR_DEL            = 8'h7F;
  localparam logic [15:0]        GLYPH_HOUSE         = 16'h2302;
  localparam logic [RunW-1:0]    RUN_MAX             = 8'd255;

  // Configuration register indexes
  localparam logic REG_ROW_WIDTH   = 1'b0;
  localparam logic REG_BYTE_BUDGET = 1'b1;

  localparam logic [15:0] LOW_GLYPH [0:31] = '{
    16'h0020, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
    16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
  };

  localparam logic [15:0] HIGH_GLYPH [0:127] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  // Encoded glyph of one cell
  typedef struct packed {
    logic [LenW-1:0]  len;
    logic [CharW-1:0] b0;
    logic [CharW-1:0] b1;
    logic [CharW-1:0] b2;
  } glyph_t;

  // One result item
  typedef struct packed {
    logic             put_newline;
    logic [RunW-1:0]  space_run;
    logic [LenW-1:0]  byte_count;
    logic [CharW-1:0] utf8_first;
    logic [CharW-1:0] utf8_second;
    logic [CharW-1:0] utf8_third;
    logic             text_end;
    logic             budget_hit;
  } result_t;

endpackage

@@ rtl/text_screen_to_utf8_stream_unit.sv @@
// Top level: screen cell stream to UTF-8 result stream with config port.
// Path: a cell goes into the input register, then through one pass of table lookup and budget logic
//   into the result register, which drives the master side.
// Throughput: one cell per cycle while the master side takes results; column/space/byte counters update per cell.
// Reset (rst, synchronous): clears the valid flags of both register stages and the screen state;
//   row_width returns to 80 and byte_budget to 0xFFFFFF.
`timescale 1ns / 1ps
module text_screen_to_utf8_stream_unit (
  input  logic                         clk,
  input  logic                         rst,
  // slave side: cell stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] cell_char
  input  logic                         s_axis_tlast,  // final_cell
  // master side: result stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [0] put_newline, [8:1] space_run, [10:9] byte_count, [18:11] utf8_first,
  // [26:19] utf8_second, [34:27] utf8_third, [35] budget_hit, [39:36] zero
  output logic [39:0]                  m_axis_tdata,
  output logic                         m_axis_tlast,  // text_end
  // configuration write port
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [ts2u_pkg::BudgetW-1:0] cfg_data
);
  import ts2u_pkg::*;

  // configuration registers
  logic [CharW-1:0]   row_width;
  logic [BudgetW-1:0] byte_budget;

  // input register stage
  logic               in_valid;
  logic [CharW-1:0]   in_char;
  logic               in_last;

  // result register stage
  result_t            res_reg;
  result_t            res_comb;
  glyph_t             glyph;

  logic               out_free;
  logic               advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= DEFAULT_ROW_WIDTH;
      byte_budget <= DEFAULT_BYTE_BUDGET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW_WIDTH:   row_width   <= cfg_data[CharW-1:0];
        REG_BYTE_BUDGET: byte_budget <= cfg_data;
        default:         row_width   <= row_width;
      endcase
    end
  end

  // Result register frees when empty or being taken this cycle; the input
  // register moves into it whenever it frees, so a cell can enter every cycle while results are taken.
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = in_valid && out_free;
  assign s_axis_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_char <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  ts2u_glyph_enc u_glyph_enc (
    .cell_char (in_char),
    .glyph     (glyph)
  );

  ts2u_core u_core (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .cell_char   (in_char),
    .final_cell  (in_last),
    .glyph       (glyph),
    .row_width   (row_width),
    .byte_budget (byte_budget),
    .cfg_we      (cfg_we),
    .result      (res_comb)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= res_comb;
    end
  end

  assign m_axis_tdata = {4'b0000,
                         res_reg.budget_hit,
                         res_reg.utf8_third,
                         res_reg.utf8_second,
                         res_reg.utf8_first,
                         res_reg.byte_count,
                         res_reg.space_run,
                         res_reg.put_newline};
  assign m_axis_tlast = res_reg.text_end;

endmodule

@@ rtl/ts2u_glyph_enc.sv @@
// Glyph encoder: code page 437 byte to UTF-8 bytes and length.
`timescale 1ns / 1ps
module ts2u_glyph_enc (
  input  logic [ts2u_pkg::CharW-1:0] cell_char,
  output ts2u_pkg::glyph_t           glyph
);
  import ts2u_pkg::*;

  logic [15:0] cp;

  always_comb begin
    if (cell_char < CHAR_SPACE) begin
      cp = LOW_GLYPH[cell_char[4:0]];
    end else if (cell_char < CHAR_DEL) begin
      cp = {8'h00, cell_char};
    end else if (cell_char == CHAR_DEL) begin
      cp = GLYPH_HOUSE;
    end else begin
      cp = HIGH_GLYPH[cell_char[6:0]];
    end
  end

  always_comb begin
    if (cp < 16'h0080) begin
      glyph.len = 2'd1;
      glyph.b0  = cp[7:0];
      glyph.b1  = 8'h00;
      glyph.b2  = 8'h00;
    end else if (cp < 16'h0800) begin
      glyph.len = 2'd2;
      glyph.b0  = {3'b110, cp[10:6]};
      glyph.b1  = {2'b10, cp[5:0]};
      glyph.b2  = 8'h00;
    end else begin
      glyph.len = 2'd3;
      glyph.b0  = {4'b1110, cp[15:12]};
      glyph.b1  = {2'b10, cp[11:6]};
      glyph.b2  = {2'b10, cp[5:0]};
    end
  end

endmodule

@@ rtl/ts2u_core.sv @@
// Screen state and byte budget: newline, held spaces and cut of glyph bytes.
`timescale 1ns / 1ps
module ts2u_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         advance,
  input  logic [ts2u_pkg::CharW-1:0]   cell_char,
  input  logic                         final_cell,
  input  ts2u_pkg::glyph_t             glyph,
  input  logic [ts2u_pkg::CharW-1:0]   row_width,
  input  logic [ts2u_pkg::BudgetW-1:0] byte_budget,
  input  logic                         cfg_we,
  output ts2u_pkg::result_t            result
);
  import ts2u_pkg::*;

  logic [CharW-1:0]   column_pos, column_pos_next;
  logic [RunW-1:0]    pending_spaces, pending_spaces_next;
  logic [BudgetW-1:0] bytes_emitted, bytes_emitted_next;
  logic               started_flag, started_flag_next;
  logic               drop_seen, drop_seen_next;

  logic [CharW-1:0]   width_eff;
  logic [BudgetW-1:0] remaining, rem1, rem2;
  logic               nl_due, nl, is_space;
  logic [RunW-1:0]    pend0, run;
  logic [LenW-1:0]    kept;
  logic [CharW:0]     col_inc;

  always_comb begin
    width_eff = (row_width == '0) ? DEFAULT_ROW_WIDTH : row_width;
    remaining = (byte_budget > bytes_emitted) ? byte_budget - bytes_emitted : '0;
    nl_due    = started_flag && (column_pos == '0);
    nl        = nl_due && (remaining != '0);
    rem1      = remaining - {{(BudgetW-1){1'b0}}, nl};
    pend0     = nl_due ? '0 : pending_spaces;
    is_space  = (cell_char == CHAR_NUL) || (cell_char == CHAR_SPACE);

    if (is_space) begin
      run = '0;
    end else if ({{(BudgetW-RunW){1'b0}}, pend0} <= rem1) begin
      run = pend0;
    end else begin
      run = rem1[RunW-1:0];
    end
    rem2 = rem1 - {{(BudgetW-RunW){1'b0}}, run};

    if (is_space) begin
      kept = '0;
    end else if (rem2 >= {{(BudgetW-LenW){1'b0}}, glyph.len}) begin
      kept = glyph.len;
    end else begin
      kept = rem2[LenW-1:0];
    end

    drop_seen_next = drop_seen || (nl_due && !nl) ||
                     (!is_space && ((run != pend0) || (kept != glyph.len)));

    if (!is_space) begin
      pending_spaces_next = '0;
    end else if (pend0 == RUN_MAX) begin
      pending_spaces_next = RUN_MAX;
    end else begin
      pending_spaces_next = pend0 + 8'd1;
    end

    bytes_emitted_next = bytes_emitted + {{(BudgetW-1){1'b0}}, nl}
                       + {{(BudgetW-RunW){1'b0}}, run}
                       + {{(BudgetW-LenW){1'b0}}, kept};

    col_inc         = {1'b0, column_pos} + 9'd1;
    column_pos_next = (col_inc >= {1'b0, width_eff}) ? '0 : col_inc[CharW-1:0];
    started_flag_next = 1'b1;
  end

  always_comb begin
    result.put_newline = nl;
    result.space_run   = run;
    result.byte_count  = kept;
    result.utf8_first  = (kept >= 2'd1) ? glyph.b0 : '0;
    result.utf8_second = (kept >= 2'd2) ? glyph.b1 : '0;
    result.utf8_third  = (kept == 2'd3) ? glyph.b2 : '0;
    result.text_end    = final_cell;
    result.budget_hit  = drop_seen_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pos     <= '0;
      pending_spaces <= '0;
      bytes_emitted  <= '0;
      started_flag   <= 1'b0;
      drop_seen      <= 1'b0;
    end else if (advance) begin
      if (final_cell) begin
        column_pos     <= '0;
        pending_spaces <= '0;
        bytes_emitted  <= '0;
        started_flag   <= 1'b0;
        drop_seen      <= 1'b0;
      end else begin
        column_pos     <= column_pos_next;
        pending_spaces <= pending_spaces_next;
        bytes_emitted  <= bytes_emitted_next;
        started_flag   <= started_flag_next;
        drop_seen      <= drop_seen_next;
      end
    end
  end

`ifndef ASSERT_OFF
  // end of screen returns every counter to its start
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    advance && final_cell |=> column_pos == '0 && bytes_emitted == '0 &&
                              !started_flag && !drop_seen && pending_spaces == '0)
    else $error("state not cleared after final cell");

  // once a byte is dropped the flag stays until the screen ends
  a_drop_sticky: assert property (@(posedge clk) disable iff (rst)
    advance && drop_seen && !final_cell |=> drop_seen)
    else $error("budget drop flag lost mid-screen");

  // column wraps inside the row width
  a_column_range: assert property (@(posedge clk) disable iff (rst)
    advance && !cfg_we |=> column_pos < width_eff)
    else $error("column position past row width");

  // a newline is never issued ahead of the first cell of a screen
  a_newline_started: assert property (@(posedge clk) disable iff (rst)
    advance && nl |-> started_flag)
    else $error("newline before first cell");
`endif

endmodule

@@ sim/tb_top.sv @@
// Testbench for the screen cell to UTF-8 stream unit: directed and random stimulus with a scoreboard.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned IDLE_LIMIT   = 1000;  // cycles with no transfer before giving up
  localparam int unsigned GAP_PCT      = 19;    // chance of an idle cycle on either side
  localparam int unsigned SETTLE_WAIT  = 4;     // extra wait after the results drain, as margin
  localparam int unsigned ERR_REPORTS  = 10;
  localparam logic [23:0] BUDGET_MAX   = 24'hFFFFFF;
  localparam int unsigned WIDTH_ZERO_AS = 80;
  localparam logic [15:0] HOUSE_CP     = 16'h2302;

  // Code page 437 glyphs: control range and upper half.
  localparam logic [15:0] CTRL_MAP [32] = '{
    16'h0020, 16'h263A, 16'h263B, 16'h2665, 16'h2666, 16'h2663, 16'h2660, 16'h2022,
    16'h25D8, 16'h25CB, 16'h25D9, 16'h2642, 16'h2640, 16'h266A, 16'h266B, 16'h263C,
    16'h25BA, 16'h25C4, 16'h2195, 16'h203C, 16'h00B6, 16'h00A7, 16'h25AC, 16'h21A8,
    16'h2191, 16'h2193, 16'h2192, 16'h2190, 16'h221F, 16'h2194, 16'h25B2, 16'h25BC
  };
  localparam logic [15:0] UPPER_MAP [128] = '{
    16'h00C7, 16'h00FC, 16'h00E9, 16'h00E2, 16'h00E4, 16'h00E0, 16'h00E5, 16'h00E7,
    16'h00EA, 16'h00EB, 16'h00E8, 16'h00EF, 16'h00EE, 16'h00EC, 16'h00C4, 16'h00C5,
    16'h00C9, 16'h00E6, 16'h00C6, 16'h00F4, 16'h00F6, 16'h00F2, 16'h00FB, 16'h00F9,
    16'h00FF, 16'h00D6, 16'h00DC, 16'h00A2, 16'h00A3, 16'h00A5, 16'h20A7, 16'h0192,
    16'h00E1, 16'h00ED, 16'h00F3, 16'h00FA, 16'h00F1, 16'h00D1, 16'h00AA, 16'h00BA,
    16'h00BF, 16'h2310, 16'h00AC, 16'h00BD, 16'h00BC, 16'h00A1, 16'h00AB, 16'h00BB,
    16'h2591, 16'h2592, 16'h2593, 16'h2502, 16'h2524, 16'h2561, 16'h2562, 16'h2556,
    16'h2555, 16'h2563, 16'h2551, 16'h2557, 16'h255D, 16'h255C, 16'h255B, 16'h2510,
    16'h2514, 16'h2534, 16'h252C, 16'h251C, 16'h2500, 16'h253C, 16'h255E, 16'h255F,
    16'h255A, 16'h2554, 16'h2569, 16'h2566, 16'h2560, 16'h2550, 16'h256C, 16'h2567,
    16'h2568, 16'h2564, 16'h2565, 16'h2559, 16'h2558, 16'h2552, 16'h2553, 16'h256B,
    16'h256A, 16'h2518, 16'h250C, 16'h2588, 16'h2584, 16'h258C, 16'h2590, 16'h2580,
    16'h03B1, 16'h00DF, 16'h0393, 16'h03C0, 16'h03A3, 16'h03C3, 16'h00B5, 16'h03C4,
    16'h03A6, 16'h0398, 16'h03A9, 16'h03B4, 16'h221E, 16'h03C6, 16'h03B5, 16'h2229,
    16'h2261, 16'h00B1, 16'h2265, 16'h2264, 16'h2320, 16'h2321, 16'h00F7, 16'h2248,
    16'h00B0, 16'h2219, 16'h00B7, 16'h221A, 16'h207F, 16'h00B2, 16'h25A0, 16'h00A0
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // [7:0] cell_char
  logic        s_axis_tlast = 1'b0; // final_cell
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [0] put_newline, [8:1] space_run, [10:9] byte_count, [18:11] utf8_first,
  // [26:19] utf8_second, [34:27] utf8_third, [35] budget_hit, [39:36] zero
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;        // text_end
  logic        cfg_we = 1'b0;
  logic        cfg_index = ts2u_pkg::REG_ROW_WIDTH;
  logic [23:0] cfg_data = '0;

  // Held high for one stretch of the run so back-to-back transfers get exercised.
  logic        steady_flow = 1'b0;
  int unsigned cells_left = 0;      // cells still to go in the current random screen
  int unsigned blank_pct = 0;       // share of blank cells in the current screen
  int unsigned quiet_cycles = 0;

  text_screen_to_utf8_stream_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Maps a cell byte to its Unicode code point.
  function automatic logic [15:0] cp437_code_point(logic [7:0] ch);
    if (ch < 8'h20) return CTRL_MAP[ch[4:0]];
    if (ch < ts2u_pkg::CHAR_DEL) return {8'h00, ch};
    if (ch == ts2u_pkg::CHAR_DEL) return HOUSE_CP;
    return UPPER_MAP[ch[6:0]];
  endfunction

  // Screen converter prediction plus in-order result checking.
  class screen_text_checker;
    ts2u_pkg::result_t utf8_results_q[$];
    int unsigned row_width;
    int unsigned byte_budget;
    int unsigned col;
    int unsigned held_spaces;
    int unsigned bytes_kept;
    bit          row_started;
    bit          any_dropped;
    int unsigned failures;
    int unsigned results_seen;

    function new();
      row_width = ts2u_pkg::DEFAULT_ROW_WIDTH;
      byte_budget = ts2u_pkg::DEFAULT_BYTE_BUDGET;
      failures = 0;
      results_seen = 0;
      clear_screen();
    endfunction

    function void clear_screen();
      col = 0;
      held_spaces = 0;
      bytes_kept = 0;
      row_started = 1'b0;
      any_dropped = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [23:0] val);
      if (idx == ts2u_pkg::REG_ROW_WIDTH) row_width = val[7:0];
      else byte_budget = val;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= ERR_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Called on each accepted cell transfer: predicts the one result it causes.
    function void take_cell(logic [7:0] ch, logic last);
      int unsigned w, room, run, kept, nbytes;
      logic [15:0] cp;
      logic [7:0]  enc [3];
      ts2u_pkg::result_t r;
      w = (row_width == 0) ? WIDTH_ZERO_AS : row_width;
      room = (byte_budget > bytes_kept) ? byte_budget - bytes_kept : 0;
      run = 0;
      kept = 0;
      enc = '{8'h00, 8'h00, 8'h00};
      r = '0;
      // Row boundary: trailing spaces of the old row vanish, a line feed goes out if budget is left.
      if (row_started && col == 0) begin
        held_spaces = 0;
        if (room != 0) begin
          r.put_newline = 1'b1;
          room--;
          bytes_kept++;
        end else begin
          any_dropped = 1'b1;
        end
      end
      if (ch == ts2u_pkg::CHAR_NUL || ch == ts2u_pkg::CHAR_SPACE) begin
        if (held_spaces < ts2u_pkg::RUN_MAX) held_spaces++;
      end else begin
        run = (held_spaces < room) ? held_spaces : room;
        if (run < held_spaces) any_dropped = 1'b1;
        room -= run;
        bytes_kept += run;
        held_spaces = 0;
        cp = cp437_code_point(ch);
        if (cp < 16'h0080) begin
          nbytes = 1;
          enc[0] = cp[7:0];
        end else if (cp < 16'h0800) begin
          nbytes = 2;
          enc[0] = {3'b110, cp[10:6]};
          enc[1] = {2'b10, cp[5:0]};
        end else begin
          nbytes = 3;
          enc[0] = {4'b1110, cp[15:12]};
          enc[1] = {2'b10, cp[11:6]};
          enc[2] = {2'b10, cp[5:0]};
        end
        // The budget may cut a sequence in its middle.
        kept = (nbytes < room) ? nbytes : room;
        if (kept < nbytes) any_dropped = 1'b1;
        bytes_kept += kept;
        for (int i = 0; i < 3; i++) if (i >= kept) enc[i] = 8'h00;
      end
      col = (col + 1 >= w) ? 0 : col + 1;
      row_started = 1'b1;
      r.space_run   = run[7:0];
      r.byte_count  = kept[1:0];
      r.utf8_first  = enc[0];
      r.utf8_second = enc[1];
      r.utf8_third  = enc[2];
      r.text_end    = last;
      r.budget_hit  = any_dropped;
      utf8_results_q.push_back(r);
      if (last) clear_screen();
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got)
        note_failure($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                               results_seen, name, want, got));
    endfunction

    // Called on each accepted result transfer.
    function void match_output(logic [39:0] d, logic last);
      ts2u_pkg::result_t e;
      results_seen++;
      if (utf8_results_q.size() == 0) begin
        note_failure($sformatf("result %0d arrived with none expected (data 0x%h)",
                               results_seen, d));
        return;
      end
      e = utf8_results_q.pop_front();
      compare_field("put_newline", e.put_newline, d[0]);
      compare_field("space_run",   e.space_run,   d[8:1]);
      compare_field("byte_count",  e.byte_count,  d[10:9]);
      compare_field("utf8_first",  e.utf8_first,  d[18:11]);
      compare_field("utf8_second", e.utf8_second, d[26:19]);
      compare_field("utf8_third",  e.utf8_third,  d[34:27]);
      compare_field("budget_hit",  e.budget_hit,  d[35]);
      compare_field("padding",     0,             d[39:36]);
      compare_field("text_end",    e.text_end,    last);
    endfunction
  endclass

  screen_text_checker sb = new();

  // Offer one cell, with random idle cycles first, and hold it until the transfer.
  task automatic send_cell(logic [7:0] ch, logic last);
    while (!steady_flow && $urandom_range(0, 99) < GAP_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= ch;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    sb.take_cell(ch, last);
  endtask

  // Block is idle once every predicted result has come out; then leave some margin.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.utf8_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  // One write pulse, then the enable is driven low again.
  task automatic write_reg(logic idx, logic [23:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Screens of random length and blank density; a screen may span a register change.
  task automatic random_cells(int unsigned count);
    logic [7:0] ch;
    for (int unsigned i = 0; i < count; i++) begin
      if (cells_left == 0) begin
        cells_left = ($urandom_range(0, 3) == 0) ? $urandom_range(41, 400)
                                                 : $urandom_range(1, 40);
        blank_pct = $urandom_range(0, 85);
      end
      if ($urandom_range(0, 99) < blank_pct)
        ch = $urandom_range(0, 1) ? ts2u_pkg::CHAR_SPACE : ts2u_pkg::CHAR_NUL;
      else
        ch = 8'($urandom_range(0, 255));
      cells_left--;
      send_cell(ch, cells_left == 0);
    end
  endtask

  // Result side: check each transfer, stall at random.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) sb.match_output(m_axis_tdata, m_axis_tlast);
      m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= GAP_PCT);
    end
  end

  // Watchdog: too long with no transfer on any port means the block has hung.
  initial begin
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet_cycles, sb.utf8_results_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0]  w_set;
    logic [23:0] b_set;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, reset settings: blank cells of both kinds, one-, two- and three-byte
    // glyphs, the house glyph, both ends of the byte range, a run of held spaces.
    send_cell(8'h00, 1'b0);
    send_cell(8'h20, 1'b0);
    send_cell(8'h01, 1'b0);
    send_cell(8'h7E, 1'b0);
    send_cell(8'h7F, 1'b0);
    send_cell(8'h80, 1'b0);
    send_cell(8'h14, 1'b0);
    send_cell(8'h20, 1'b0);
    send_cell(8'h00, 1'b0);
    send_cell(8'hFF, 1'b1);
    // Trailing blanks dropped at the final cell, then a screen of one blank cell.
    send_cell(8'h41, 1'b0);
    send_cell(8'h20, 1'b0);
    send_cell(8'h00, 1'b1);
    send_cell(8'h00, 1'b1);
    settle();

    // One cell per row with a tight budget: line feeds compete for budget.
    write_reg(ts2u_pkg::REG_ROW_WIDTH, 24'd1);
    write_reg(ts2u_pkg::REG_BYTE_BUDGET, 24'd3);
    send_cell(8'h41, 1'b0);
    send_cell(8'h20, 1'b0);
    send_cell(8'h42, 1'b0);
    send_cell(8'h01, 1'b1);
    settle();

    // Zero width means 80; budget cuts a three-byte sequence after a held space.
    write_reg(ts2u_pkg::REG_ROW_WIDTH, 24'd0);
    write_reg(ts2u_pkg::REG_BYTE_BUDGET, 24'd5);
    send_cell(8'h01, 1'b0);
    send_cell(8'h20, 1'b0);
    send_cell(8'h02, 1'b0);
    send_cell(8'h41, 1'b1);
    settle();

    // Zero budget keeps nothing.
    write_reg(ts2u_pkg::REG_BYTE_BUDGET, 24'd0);
    send_cell(8'h41, 1'b0);
    send_cell(8'hB3, 1'b1);
    settle();

    // Random phases; screens carry over phase boundaries, so width and budget
    // change mid-screen, including a budget dropped below what is already kept.
    for (int p = 0; p < 12; p++) begin
      steady_flow <= (p == 2);
      case (p)
        0: begin
          w_set = 8'd0;
          b_set = BUDGET_MAX;
        end
        1: begin
          w_set = 8'd255;
          b_set = BUDGET_MAX;
        end
        2: begin
          w_set = 8'd1;
          b_set = 24'($urandom_range(100, 400));
        end
        3: begin
          w_set = 8'($urandom_range(2, 9));
          b_set = 24'd0;
        end
        4: begin
          w_set = 8'($urandom_range(0, 255));
          b_set = 24'($urandom);
        end
        5: begin
          w_set = 8'($urandom_range(3, 12));
          b_set = 24'($urandom_range(0, 20));
        end
        11: begin
          w_set = 8'($urandom_range(1, 16));
          b_set = BUDGET_MAX;
        end
        default: begin
          w_set = 8'($urandom_range(1, 16));
          b_set = 24'($urandom_range(1, 400));
        end
      endcase
      write_reg(ts2u_pkg::REG_ROW_WIDTH, {16'h0000, w_set});
      write_reg(ts2u_pkg::REG_BYTE_BUDGET, b_set);
      if (p == 1) begin
        // Widest row: close the open screen, then the longest held space run.
        send_cell(8'h41, 1'b1);
        for (int i = 0; i < 254; i++) send_cell(ts2u_pkg::CHAR_SPACE, 1'b0);
        send_cell(8'hDB, 1'b0);
        send_cell(8'h20, 1'b1);
        cells_left = 0;
      end
      random_cells(100);
      settle();
    end

    // End: everything drained (settle above), then a further wait for stray results.
    repeat (8) @(posedge clk);
    if (sb.utf8_results_q.size() != 0)
      sb.note_failure($sformatf("%0d expected results never arrived",
                                sb.utf8_results_q.size()));
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/ts2u_pkg.sv
rtl/ts2u_glyph_enc.sv
rtl/ts2u_core.sv
rtl/text_screen_to_utf8_stream_unit.sv
sim/tb_top.sv
